// ===== rtl/core/auto_exposure_adapter_assert.svh =====
// assertion helpers for the auto exposure adapter
`ifndef AUTO_EXPOSURE_ADAPTER_ASSERT_SVH
`define AUTO_EXPOSURE_ADAPTER_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define AEA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("auto exposure adapter check failed");

// next-cycle implication, clocked on clk_i, off during reset
`define AEA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("auto exposure adapter check failed");

`endif

// ===== rtl/core/aea_pkg.sv =====
`default_nettype none

package aea_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_KEY   = 2'd0;
  localparam logic [1:0] REG_MIN   = 2'd1;
  localparam logic [1:0] REG_MAX   = 2'd2;
  localparam logic [1:0] REG_SPEED = 2'd3;

  // fixed-point constants
  localparam logic [30:0] LOG2E_Q30     = 31'd1549082005;
  localparam logic [20:0] LOG_SAT       = 21'd1048576;
  localparam logic [55:0] LUM_FLOOR_Q32 = 56'd4294967;
  localparam int unsigned FRAC_BITS     = 46;
  localparam int unsigned DIV_STEPS     = 56;

  // shared unit operations
  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_MUL,
    UOP_MAC_HI,
    UOP_LOAD,
    UOP_DIV
  } unit_op_e;

  typedef struct packed {
    unit_op_e    op;
    logic [31:0] a;
    logic [31:0] b;
  } unit_req_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXP_MUL,
    ST_EXP_ARG,
    ST_EXP_TBL,
    ST_EXP_LO,
    ST_EXP_HI,
    ST_EXP_FIN,
    ST_DIV_LOAD,
    ST_DIV,
    ST_P_MUL,
    ST_P_FIN,
    ST_STEP_MUL,
    ST_OUT
  } state_e;

  // clamp to [mn, mx], mn wins when the bounds cross
  function automatic logic [23:0] clamp_exp(logic [55:0] v, logic [23:0] mn,
                                            logic [23:0] mx);
    logic [55:0] r;
    r = v;
    if (r > 56'(mx)) r = 56'(mx);
    if (r < 56'(mn)) r = 56'(mn);
    return r[23:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/aea_exp_rom.sv =====
`default_nettype none

module aea_exp_rom import aea_pkg::*; #(
  parameter int unsigned ADDR_BITS = 8
) (
  input  wire logic [ADDR_BITS-1:0] idx_i,
  output logic      [23:0]          t0_o,
  output logic      [24:0]          t1_o
);

  localparam int unsigned Size = 1 << ADDR_BITS;

  typedef logic [23:0] tbl_t [Size];

  // integer square root, bit by bit
  function automatic logic [63:0] isqrt64(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] nn;
    res   = '0;
    bit_v = 64'd1 << 62;
    nn    = n;
    for (int j = 0; j < 32; j++) begin
      if (bit_v > nn) bit_v = bit_v >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (bit_v != 64'd0) begin
        if (nn >= res + bit_v) begin
          nn  = nn - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  // powers of 2^(1/Size) in Q1.23, accumulated in Q2.30
  function automatic tbl_t build_tbl();
    tbl_t        t;
    logic [63:0] r;
    logic [63:0] acc;
    r   = 64'd2 << 30;
    acc = 64'd1 << 30;
    for (int i = 0; i < int'(ADDR_BITS); i++) r = isqrt64(r << 30);
    for (int i = 0; i < int'(Size); i++) begin
      t[i] = 24'((acc + 64'd64) >> 7);
      acc  = (acc * r + (64'd1 << 29)) >> 30;
    end
    return t;
  endfunction

  localparam tbl_t Tbl = build_tbl();

  // entry and its upper neighbour, 2.0 past the end
  assign t0_o = Tbl[idx_i];
  assign t1_o = (idx_i == ADDR_BITS'(Size - 1)) ? 25'h100_0000
                                                 : {1'b0, Tbl[idx_i + 1'b1]};

endmodule

`default_nettype wire

// ===== rtl/core/aea_unit.sv =====
`default_nettype none

module aea_unit import aea_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire unit_req_t   req_i,
  input  wire logic [55:0] divisor_i,
  output logic      [63:0] acc_o
);

  logic [63:0] acc_q, acc_d;
  logic [55:0] rem_q, rem_d;
  logic [63:0] prod;
  logic [56:0] trial;
  logic        ge;

  // one 32x32 multiplier and one restoring divide step
  assign prod  = {32'd0, req_i.a} * {32'd0, req_i.b};
  assign trial = {rem_q, acc_q[55]};
  assign ge    = trial >= {1'b0, divisor_i};

  always_comb begin
    acc_d = acc_q;
    rem_d = rem_q;
    case (req_i.op)
      UOP_MUL:    acc_d = prod;
      UOP_MAC_HI: acc_d = acc_q + {prod[31:0], 32'd0};
      UOP_LOAD: begin
        acc_d = {req_i.a, req_i.b};
        rem_d = '0;
      end
      UOP_DIV: begin
        rem_d = ge ? 56'(trial - {1'b0, divisor_i}) : trial[55:0];
        acc_d = {acc_q[62:0], ge};
      end
      default: ;
    endcase
  end

  // accumulator and partial remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      rem_q <= '0;
    end else begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// ===== rtl/core/auto_exposure_adapter.sv =====
// channel   dir  fields (low bit first)                         beat taken when
// s_axis    in   tdata: log_lum_half, delta_time; tuser: valid  tvalid & tready
// m_axis    out  tdata: exposure                                tvalid & tready
// cfg       in   idx, data (key, min, max, speed)              we
//
// one frame beat passes from acceptance to the result register through the
// restoring divider for key over luminance, two exponentials of six steps each
// and a few multiplies, all on the shared unit.
// input ready is low from acceptance until the result is loaded; a stalled
// result holds the block in its last step. reset loads the default registers,
// an exposure of 1.0 and a stored log luminance of zero.
`default_nettype none
`include "auto_exposure_adapter_assert.svh"

module auto_exposure_adapter import aea_pkg::*; #(
  parameter int unsigned EXP_TABLE_ADDR_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // log_lum_half, delta_time
  input  wire logic        s_axis_tuser_i,  // sample_valid
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [23:0] m_axis_tdata_o,  // exposure
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_data_i
);

  localparam int unsigned RemBits = FRAC_BITS - EXP_TABLE_ADDR_BITS;

  state_e state_q, state_d;
  logic        pass_q;
  logic [5:0]  cnt_q;
  logic        m_valid_q;
  logic [23:0] key_q, min_q, max_q;
  logic [15:0] speed_q;
  logic [23:0] cur_q;
  logic signed [21:0] log_q;

  logic signed [21:0] x_q;
  logic [51:0] u_q;
  logic [23:0] t0_q, diff_q;
  logic [55:0] lum_q;
  logic [31:0] rate_q;
  logic [15:0] dt_q;
  logic [23:0] target_q;
  logic        up_q;
  logic [23:0] out_q;

  unit_req_t   req;
  logic [63:0] acc;
  logic [23:0] rom_t0;
  logic [24:0] rom_t1;

  logic        in_beat, out_free;
  logic signed [21:0] dec;
  logic [20:0] x_abs;
  logic [52:0] y_mag;
  logic [24:0] val;
  logic [5:0]  kk;
  logic [56:0] shifted;
  logic [32:0] e_cl;
  logic [32:0] p_sum;
  logic [28:0] p_raw;
  logic [20:0] p_sat;
  logic [23:0] d_abs;
  logic [56:0] step_sum;
  logic [24:0] step;
  logic [24:0] cur_nxt;
  logic [23:0] cur_cl;

  // half decode: subnormals, round to Q16, saturate at 16.0
  function automatic logic signed [21:0] decode_half(logic [15:0] h);
    logic [4:0]  e;
    logic [4:0]  ee;
    logic [4:0]  sh;
    logic [10:0] m;
    logic [32:0] mag;
    e   = h[14:10];
    m   = (e == 5'd0) ? {1'b0, h[9:0]} : {1'b1, h[9:0]};
    ee  = (e == 5'd0) ? 5'd1 : e;
    sh  = '0;
    mag = '0;
    if (ee >= 5'd9) begin
      mag = 33'(m) << (ee - 5'd9);
    end else begin
      sh  = 5'd9 - ee;
      mag = (33'(m) + (33'd1 << (sh - 5'd1))) >> sh;
    end
    if (mag > 33'(LOG_SAT)) mag = 33'(LOG_SAT);
    if (e == 5'd31) mag = '0;
    return h[15] ? -22'(mag) : 22'(mag);
  endfunction

  aea_unit u_unit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .divisor_i (lum_q),
    .acc_o     (acc)
  );

  aea_exp_rom #(
    .ADDR_BITS (EXP_TABLE_ADDR_BITS)
  ) u_rom (
    .idx_i (u_q[FRAC_BITS-1 -: EXP_TABLE_ADDR_BITS]),
    .t0_o  (rom_t0),
    .t1_o  (rom_t1)
  );

  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign dec      = decode_half(s_axis_tdata_i[15:0]);

  // exponential datapath
  assign x_abs   = x_q[21] ? 21'(-x_q) : 21'(x_q);
  assign y_mag   = x_q[21] ? 53'(~acc[52:0] + 53'd1) : acc[52:0];
  assign val     = 25'(t0_q) + 25'(acc >> RemBits);
  assign kk      = u_q[51:46];
  assign shifted = (kk >= 6'd23) ? (57'(val) << (kk - 6'd23))
                                 : (57'(val) >> (6'd23 - kk));
  assign e_cl    = (shifted > 57'h1_0000_0000) ? 33'h1_0000_0000 : shifted[32:0];

  // rate argument speed*dt rounded to Q16
  assign p_sum = 33'(acc[31:0]) + 33'd8;
  assign p_raw = p_sum[32:4];
  assign p_sat = (p_raw > 29'(LOG_SAT)) ? LOG_SAT : p_raw[20:0];

  // smoothing step
  assign d_abs    = (target_q >= cur_q) ? target_q - cur_q : cur_q - target_q;
  assign step_sum = 57'(acc[55:0]) + 57'h8000_0000;
  assign step     = step_sum[56:32];
  assign cur_nxt  = up_q ? 25'(cur_q) + step : 25'(cur_q) - step;
  assign cur_cl   = clamp_exp(56'(cur_nxt), min_q, max_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_beat) state_d = ST_EXP_MUL;
      ST_EXP_MUL:  state_d = ST_EXP_ARG;
      ST_EXP_ARG:  state_d = ST_EXP_TBL;
      ST_EXP_TBL:  state_d = ST_EXP_LO;
      ST_EXP_LO:   state_d = ST_EXP_HI;
      ST_EXP_HI:   state_d = ST_EXP_FIN;
      ST_EXP_FIN:  state_d = pass_q ? ST_STEP_MUL : ST_DIV_LOAD;
      ST_DIV_LOAD: state_d = ST_DIV;
      ST_DIV:      if (cnt_q == 6'(DIV_STEPS - 1)) state_d = ST_P_MUL;
      ST_P_MUL:    state_d = ST_P_FIN;
      ST_P_FIN:    state_d = ST_EXP_MUL;
      ST_STEP_MUL: state_d = ST_OUT;
      ST_OUT:      if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // shared unit requests
  always_comb begin
    req.op = UOP_NOP;
    req.a  = '0;
    req.b  = '0;
    unique case (state_q)
      ST_EXP_MUL: begin
        req.op = UOP_MUL;
        req.a  = 32'(x_abs);
        req.b  = 32'(LOG2E_Q30);
      end
      ST_EXP_LO: begin
        req.op = UOP_MUL;
        req.a  = 32'(diff_q);
        req.b  = u_q[31:0];
      end
      ST_EXP_HI: begin
        req.op = UOP_MAC_HI;
        req.a  = 32'(diff_q);
        req.b  = 32'(u_q[RemBits-1:32]);
      end
      ST_DIV_LOAD: begin
        req.op = UOP_LOAD;
        req.a  = 32'(key_q);
      end
      ST_DIV:      req.op = UOP_DIV;
      ST_P_MUL: begin
        req.op = UOP_MUL;
        req.a  = 32'(speed_q);
        req.b  = 32'(dt_q);
      end
      ST_STEP_MUL: begin
        req.op = UOP_MUL;
        req.a  = 32'(d_abs);
        req.b  = rate_q;
      end
      default: ;
    endcase
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_q;

  // control state, configuration and stored exposure
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pass_q    <= 1'b0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      key_q     <= 24'd11796;
      min_q     <= 24'd6554;
      max_q     <= 24'd655360;
      speed_q   <= 16'd256;
      cur_q     <= 24'd65536;
      log_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_KEY:   key_q   <= cfg_data_i;
          REG_MIN:   min_q   <= cfg_data_i;
          REG_MAX:   max_q   <= cfg_data_i;
          REG_SPEED: speed_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_beat) begin
        pass_q <= 1'b0;
        if (s_axis_tuser_i) log_q <= dec;
      end
      if (state_q == ST_P_FIN) pass_q <= 1'b1;
      if (state_q == ST_DIV_LOAD) cnt_q <= '0;
      else if (state_q == ST_DIV) cnt_q <= cnt_q + 6'd1;
      if (state_q == ST_OUT && out_free) begin
        m_valid_q <= 1'b1;
        cur_q     <= cur_cl;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      x_q  <= s_axis_tuser_i ? dec : log_q;
      dt_q <= s_axis_tdata_i[31:16];
    end
    if (state_q == ST_EXP_ARG) u_q <= y_mag[51:0] + {1'b1, 51'd0};
    if (state_q == ST_EXP_TBL) begin
      t0_q   <= rom_t0;
      diff_q <= 24'(rom_t1 - 25'(rom_t0));
    end
    if (state_q == ST_EXP_FIN) begin
      if (pass_q) rate_q <= 32'(33'h1_0000_0000 - e_cl);
      else lum_q <= (shifted < 57'(LUM_FLOOR_Q32)) ? LUM_FLOOR_Q32 : shifted[55:0];
    end
    if (state_q == ST_P_MUL) target_q <= clamp_exp(acc[55:0], min_q, max_q);
    if (state_q == ST_P_FIN) x_q <= -22'(p_sat);
    if (state_q == ST_STEP_MUL) up_q <= (target_q >= cur_q);
    if (state_q == ST_OUT && out_free) out_q <= cur_cl;
  end

  // checks
  `AEA_ASSERT_NXT(a_busy_after_beat, in_beat, !s_axis_tready_o)
  `AEA_ASSERT_IMP(a_out_in_bounds, m_axis_tvalid_o,
    (m_axis_tdata_o >= min_q) && ((m_axis_tdata_o <= max_q) || (m_axis_tdata_o == min_q)))
  `AEA_ASSERT_NXT(a_result_loaded, (state_q == ST_OUT) && !m_valid_q,
    m_axis_tvalid_o && (state_q == ST_IDLE))

endmodule

`default_nettype wire
